### hdl/ddcc_pkg.sv
// Shared types, codes and constants for the differential drive command controller.
// Used by ddcc_lane and the top level; depends on nothing.
`default_nettype none
package ddcc_pkg;

	localparam int InTdataW  = 136;
	localparam int OutTdataW = 56;
	localparam int DivBits   = 26;
	localparam int CntW      = $clog2(DivBits);
	localparam int Lanes     = 4;

	localparam logic [14:0] TargetLimitRst = 15'd15000;
	localparam logic [14:0] SlewStepRst    = 15'd500;
	localparam logic [9:0]  PwmLimitRst    = 10'd800;
	localparam logic [14:0] FullSpeedRst   = 15'd15000;
	localparam logic [31:0] TimeoutRst     = 32'd500;
	localparam logic [3:0]  WheelEnRst     = 4'hF;
	localparam logic [14:0] ClearLimitRst  = 15'd100;
	localparam bit          RearDriveDef   = 1'b0;

	typedef enum logic [2:0] {
		FUNC_TICK    = 3'd0,
		FUNC_ACQUIRE = 3'd1,
		FUNC_SPEED   = 3'd2,
		FUNC_STOP    = 3'd3,
		FUNC_RELEASE = 3'd4,
		FUNC_ESTOP   = 3'd5,
		FUNC_CLEAR   = 3'd6
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD     = 2'd1,
		ST_FAULTED = 2'd2,
		ST_BUSY    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CFG_TARGET_LIMIT = 3'd0,
		CFG_SLEW_STEP    = 3'd1,
		CFG_PWM_LIMIT    = 3'd2,
		CFG_FULL_SPEED   = 3'd3,
		CFG_TIMEOUT      = 3'd4,
		CFG_WATCHDOG     = 3'd5,
		CFG_WHEEL_EN     = 3'd6,
		CFG_CLEAR_LIMIT  = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_DIV,
		FSM_DONE
	} fsm_t;

	// Scaling settings that every lane shares.
	typedef struct packed {
		logic [9:0]  pwm_limit;
		logic [14:0] full_speed;
	} lane_cfg_t;

	// Symmetric clamp of a widened side value to the target limit.
	function automatic logic signed [15:0] clamp_tgt(input logic signed [17:0] x,
			input logic [14:0] lim);
		logic signed [17:0] l;
		logic signed [17:0] r;
		l = signed'({3'b000, lim});
		if (x > l) begin
			r = l;
		end else if (x < -l) begin
			r = -l;
		end else begin
			r = x;
		end
		return r[15:0];
	endfunction

endpackage
`default_nettype wire

### hdl/differential_drive_command_controller_top.sv
// Top level of the differential drive command controller: command decode,
// watchdog, slew and the merge of four ddcc_lane results. Depends on ddcc_pkg.
`default_nettype none
// One input word is taken at a time. A command word, or a tick that is stopped
// or trips the watchdog, goes through the done state into the output register.
// A tick in speed mode runs four lanes in parallel, each with a 26-step serial
// divider, and its result is registered once all four lanes are done. The block
// is ready for the next word as the result is loaded into the output register.
// A stalled output holds the block until the result word leaves that register.
// Rear drive outputs stay zero unless REAR_DRIVE is 1. Configuration writes are
// always accepted and should only be made while the block is idle.
module differential_drive_command_controller_top import ddcc_pkg::*; #(
	parameter bit REAR_DRIVE = RearDriveDef
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// owner_id[1:0], linear_cps[17:2], turn_cps[33:18], now_ms[65:34],
	// speed_fl[81:66], speed_fr[97:82], speed_rl[113:98], speed_rr[129:114], zeros
	input  wire logic [InTdataW-1:0]  s_tdata,
	// func[2:0]
	input  wire logic [2:0]           s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// status[1:0], drive_on[2], drive_fl[13:3], drive_fr[24:14], drive_rl[35:25],
	// drive_rr[46:36], speed_mode[47], fault_code[48], current_owner[50:49], zeros
	output logic [OutTdataW-1:0]      m_tdata,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [31:0]          cfg_data
);

	logic [14:0] target_limit_q, slew_step_q, full_speed_q, clear_limit_q;
	logic [9:0]  pwm_limit_q;
	logic [31:0] timeout_q;
	logic        watchdog_q;
	logic [3:0]  wheel_en_q;

	logic               mode_q, fault_q;
	logic [1:0]         owner_q;
	logic signed [15:0] lgoal_q, rgoal_q, lapp_q, rapp_q;
	logic [31:0]        last_q;

	fsm_t state_q, state_d;
	logic go_q;
	logic [1:0] res_status_q;
	logic       res_on_q;
	logic signed [10:0] res_drv_q [Lanes];
	logic [OutTdataW-1:0] out_q;
	logic out_valid_q;

	logic [2:0]         func;
	logic [1:0]         own;
	logic signed [15:0] lin, turn;
	logic [31:0]        now;
	logic signed [15:0] spd [Lanes];

	logic               accept;
	logic               run_tick;
	logic [1:0]         status_d;
	logic               mode_d, fault_d;
	logic [1:0]         owner_d;
	logic signed [15:0] lgoal_d, rgoal_d, lapp_d, rapp_d;
	logic [31:0]        last_d;
	logic               out_free;
	logic [Lanes-1:0]   lane_done;
	logic               lanes_done;
	logic signed [10:0] lane_drv [Lanes];
	lane_cfg_t          lcfg;

	assign func = s_tuser;
	assign own  = s_tdata[1:0];
	assign lin  = signed'(s_tdata[17:2]);
	assign turn = signed'(s_tdata[33:18]);
	assign now  = s_tdata[65:34];
	assign spd[0] = signed'(s_tdata[81:66]);
	assign spd[1] = signed'(s_tdata[97:82]);
	assign spd[2] = signed'(s_tdata[113:98]);
	assign spd[3] = signed'(s_tdata[129:114]);

	assign cfg_ready  = 1'b1;
	assign s_tready   = (state_q == FSM_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign out_free   = !out_valid_q || m_tready;
	assign lanes_done = &lane_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_limit_q <= TargetLimitRst;
			slew_step_q    <= SlewStepRst;
			pwm_limit_q    <= PwmLimitRst;
			full_speed_q   <= FullSpeedRst;
			timeout_q      <= TimeoutRst;
			watchdog_q     <= 1'b1;
			wheel_en_q     <= WheelEnRst;
			clear_limit_q  <= ClearLimitRst;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TARGET_LIMIT: target_limit_q <= cfg_data[14:0];
				CFG_SLEW_STEP:    slew_step_q    <= cfg_data[14:0];
				CFG_PWM_LIMIT:    pwm_limit_q    <= cfg_data[9:0];
				CFG_FULL_SPEED:   full_speed_q   <= cfg_data[14:0];
				CFG_TIMEOUT:      timeout_q      <= cfg_data;
				CFG_WATCHDOG:     watchdog_q     <= cfg_data[0];
				CFG_WHEEL_EN:     wheel_en_q     <= cfg_data[3:0];
				CFG_CLEAR_LIMIT:  clear_limit_q  <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Command decode and per-word state update.
	always_comb begin
		logic signed [15:0] l, t;
		logic signed [17:0] dl, dr, st;
		logic               stop_all;
		logic               too_fast;
		status_d = ST_OK;
		mode_d   = mode_q;
		fault_d  = fault_q;
		owner_d  = owner_q;
		lgoal_d  = lgoal_q;
		rgoal_d  = rgoal_q;
		lapp_d   = lapp_q;
		rapp_d   = rapp_q;
		last_d   = last_q;
		run_tick = 1'b0;
		stop_all = 1'b0;
		too_fast = 1'b0;
		l  = '0;
		t  = '0;
		st = signed'({3'b000, slew_step_q});
		dl = 18'(lgoal_q) - 18'(lapp_q);
		dr = 18'(rgoal_q) - 18'(rapp_q);
		case (func)
			FUNC_TICK: begin
				if (mode_q) begin
					if (watchdog_q && (now - last_q) >= timeout_q) begin
						stop_all = 1'b1;
						owner_d  = '0;
						fault_d  = 1'b1;
						status_d = ST_FAULTED;
					end else begin
						run_tick = 1'b1;
						if (dl > st) lapp_d = 16'(18'(lapp_q) + st);
						else if (dl < -st) lapp_d = 16'(18'(lapp_q) - st);
						else lapp_d = lgoal_q;
						if (dr > st) rapp_d = 16'(18'(rapp_q) + st);
						else if (dr < -st) rapp_d = 16'(18'(rapp_q) - st);
						else rapp_d = rgoal_q;
					end
				end
			end
			FUNC_ACQUIRE: begin
				if (own == '0) status_d = ST_BAD;
				else if (fault_q) status_d = ST_FAULTED;
				else if (owner_q != '0 && owner_q != own) status_d = ST_BUSY;
				else begin
					if (owner_q == '0) last_d = now;
					owner_d = own;
				end
			end
			FUNC_SPEED: begin
				if (fault_q) status_d = ST_FAULTED;
				else if (own == '0 || owner_q != own) status_d = ST_BUSY;
				else begin
					l = clamp_tgt(18'(lin), target_limit_q);
					t = clamp_tgt(18'(turn), target_limit_q);
					lgoal_d = clamp_tgt(18'(l) - 18'(t), target_limit_q);
					rgoal_d = clamp_tgt(18'(l) + 18'(t), target_limit_q);
					mode_d  = 1'b1;
					last_d  = now;
				end
			end
			FUNC_STOP: begin
				if (own == '0 || owner_q != own) status_d = ST_BUSY;
				else begin
					stop_all = 1'b1;
					last_d   = now;
				end
			end
			FUNC_RELEASE: begin
				if (own == '0 || owner_q != own) status_d = ST_BUSY;
				else begin
					stop_all = 1'b1;
					owner_d  = '0;
					last_d   = '0;
				end
			end
			FUNC_ESTOP: begin
				stop_all = 1'b1;
				owner_d  = '0;
				last_d   = '0;
			end
			FUNC_CLEAR: begin
				if (fault_q) begin
					for (int i = 0; i < Lanes; i++) begin
						if (wheel_en_q[i] && (spd[i][15] ? 17'(-18'(spd[i]))
								: 17'(spd[i])) > 17'(clear_limit_q)) begin
							too_fast = 1'b1;
						end
					end
					if (mode_q || too_fast) status_d = ST_BUSY;
					else begin
						fault_d = 1'b0;
						last_d  = '0;
					end
				end
			end
			default: status_d = ST_BAD;
		endcase
		if (stop_all) begin
			mode_d  = 1'b0;
			lgoal_d = '0;
			rgoal_d = '0;
			lapp_d  = '0;
			rapp_d  = '0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: if (accept) state_d = run_tick ? FSM_DIV : FSM_DONE;
			FSM_DIV:  if (lanes_done) state_d = FSM_DONE;
			FSM_DONE: if (out_free) state_d = FSM_IDLE;
			default:  state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
			mode_q      <= 1'b0;
			fault_q     <= 1'b0;
			owner_q     <= '0;
			lgoal_q     <= '0;
			rgoal_q     <= '0;
			lapp_q      <= '0;
			rapp_q      <= '0;
			last_q      <= '0;
		end else begin
			state_q <= state_d;
			go_q    <= accept && run_tick;
			if (accept) begin
				mode_q  <= mode_d;
				fault_q <= fault_d;
				owner_q <= owner_d;
				lgoal_q <= lgoal_d;
				rgoal_q <= rgoal_d;
				lapp_q  <= lapp_d;
				rapp_q  <= rapp_d;
				last_q  <= last_d;
			end
			if (state_q == FSM_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_status_q <= status_d;
			res_on_q     <= run_tick;
			for (int i = 0; i < Lanes; i++) res_drv_q[i] <= '0;
		end else if (state_q == FSM_DIV && lanes_done) begin
			for (int i = 0; i < Lanes; i++) res_drv_q[i] <= lane_drv[i];
		end
		if (state_q == FSM_DONE && out_free) begin
			out_q <= {5'b0, owner_q, fault_q, mode_q, res_drv_q[3], res_drv_q[2],
				res_drv_q[1], res_drv_q[0], res_on_q, res_status_q};
		end
	end

	assign lcfg = '{pwm_limit: pwm_limit_q, full_speed: full_speed_q};

	for (genvar g = 0; g < Lanes; g++) begin : g_lane
		ddcc_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (go_q),
			.target ((g % 2 == 0) ? lapp_q : rapp_q),
			.enable (wheel_en_q[g] && (g < 2 || REAR_DRIVE)),
			.cfg    (lcfg),
			.done   (lane_done[g]),
			.drive  (lane_drv[g])
		);
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule
`default_nettype wire

### hdl/ddcc_lane.sv
// One wheel lane: feedforward scaling of a side target into a drive permille.
// Multiplies, then divides bit-serially and clamps. Depends on ddcc_pkg.
`default_nettype none
module ddcc_lane import ddcc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [15:0] target,
	input  wire logic               enable,
	input  wire lane_cfg_t          cfg,
	output logic                    done,
	output logic signed [10:0]      drive
);

	logic                busy_q;
	logic                fin_q;
	logic                done_q;
	logic [CntW-1:0]     cnt_q;
	logic [DivBits-1:0]  quo_q;
	logic [14:0]         rem_q;
	logic [14:0]         div_q;
	logic [9:0]          lim_q;
	logic                neg_q;
	logic                zero_q;
	logic signed [10:0]  drive_q;

	logic [15:0]         mag;
	logic [15:0]         trial;
	logic                fits;
	logic [10:0]         clipped;

	assign mag   = target[15] ? 16'(-target) : 16'(target);
	assign trial = {rem_q, quo_q[DivBits-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_comb begin
		if (quo_q > DivBits'(lim_q)) begin
			clipped = {1'b0, lim_q};
		end else begin
			clipped = quo_q[10:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(DivBits - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= DivBits'(mag * cfg.pwm_limit);
			rem_q  <= '0;
			div_q  <= (cfg.full_speed == '0) ? 15'd1 : cfg.full_speed;
			lim_q  <= cfg.pwm_limit;
			neg_q  <= target[15];
			zero_q <= !enable || (target == '0);
		end else if (busy_q) begin
			// Restoring division: the quotient shifts in where the dividend leaves.
			if (fits) begin
				rem_q <= 15'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[14:0];
			end
			quo_q <= {quo_q[DivBits-2:0], fits};
		end
		if (fin_q) begin
			if (zero_q) begin
				drive_q <= '0;
			end else if (neg_q) begin
				drive_q <= -signed'(clipped);
			end else begin
				drive_q <= signed'(clipped);
			end
		end
	end

	assign done  = done_q;
	assign drive = drive_q;

endmodule
`default_nettype wire
